>>> hdl/ffc_pkg.sv
// Shared types, key and operator codes, and the microcode store of the calculator core.
package ffc_pkg;

   localparam int SHOWN_W  = 48;
   localparam int STATUS_W = 2;
   localparam int PEND_W   = 3;
   localparam int PC_W     = 4;
   localparam int SCALE_W  = 24;

   // Key kinds.
   localparam logic [2:0] KIND_DIGIT    = 3'd0;
   localparam logic [2:0] KIND_POINT    = 3'd1;
   localparam logic [2:0] KIND_OPERATOR = 3'd2;
   localparam logic [2:0] KIND_EQUALS   = 3'd3;
   localparam logic [2:0] KIND_CLEAR    = 3'd4;

   // Operator key codes.
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // Pending operation codes.
   localparam logic [PEND_W-1:0] PEND_NONE = 3'd0;
   localparam logic [PEND_W-1:0] PEND_ADD  = 3'd1;
   localparam logic [PEND_W-1:0] PEND_SUB  = 3'd2;
   localparam logic [PEND_W-1:0] PEND_MUL  = 3'd3;
   localparam logic [PEND_W-1:0] PEND_DIV  = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd2;

   // Microcode addresses.
   localparam logic [PC_W-1:0] UA_DIGIT     = 4'd0;
   localparam logic [PC_W-1:0] UA_POINT     = 4'd1;
   localparam logic [PC_W-1:0] UA_CLEAR     = 4'd2;
   localparam logic [PC_W-1:0] UA_IGNORE    = 4'd3;
   localparam logic [PC_W-1:0] UA_EQUALS    = 4'd4;
   localparam logic [PC_W-1:0] UA_OPERATOR  = 4'd5;
   localparam logic [PC_W-1:0] UA_PEND_TYPE = 4'd6;
   localparam logic [PC_W-1:0] UA_ADDSUB    = 4'd7;
   localparam logic [PC_W-1:0] UA_LOAD_MUL  = 4'd8;
   localparam logic [PC_W-1:0] UA_MUL_LOOP  = 4'd9;
   localparam logic [PC_W-1:0] UA_LOAD_DIV  = 4'd10;
   localparam logic [PC_W-1:0] UA_DIV_LOOP  = 4'd11;
   localparam logic [PC_W-1:0] UA_FINISH    = 4'd12;
   localparam logic [PC_W-1:0] UA_COMMIT    = 4'd13;
   localparam logic [PC_W-1:0] UA_DIV_ZERO  = 4'd14;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] digit;
      logic [1:0] op_code;
   } req_payload_type;

   typedef struct packed {
      logic signed [SHOWN_W-1:0] shown_value;
      logic [STATUS_W-1:0]       status;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_DIGIT,
      UOP_POINT,
      UOP_CLEAR,
      UOP_ADDSUB,
      UOP_LOAD_MUL,
      UOP_MUL_STEP,
      UOP_LOAD_DIV,
      UOP_DIV_STEP,
      UOP_FINISH,
      UOP_COMMIT,
      UOP_DIV_ZERO
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_PEND,
      COND_NO_CALC,
      COND_MUL_DIV,
      COND_DIV_ZERO,
      COND_MORE
   } cond_type;

   typedef struct packed {
      uop_type         uop;
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic            done;
   } ucode_word_type;

   function automatic logic [SCALE_W-1:0] pow_ten(input logic [2:0] idx);
      logic [SCALE_W-1:0] p;
      unique case (idx)
         3'd0:    p = 24'd1;
         3'd1:    p = 24'd10;
         3'd2:    p = 24'd100;
         3'd3:    p = 24'd1000;
         3'd4:    p = 24'd10000;
         3'd5:    p = 24'd100000;
         3'd6:    p = 24'd1000000;
         default: p = 24'd10000000;
      endcase
      return p;
   endfunction

   function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] kind);
      logic [PC_W-1:0] a;
      unique case (kind)
         KIND_DIGIT:    a = UA_DIGIT;
         KIND_POINT:    a = UA_POINT;
         KIND_OPERATOR: a = UA_OPERATOR;
         KIND_EQUALS:   a = UA_EQUALS;
         KIND_CLEAR:    a = UA_CLEAR;
         default:       a = UA_IGNORE;
      endcase
      return a;
   endfunction

   // The control store: one word per step.
   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_word_type w;
      w.uop    = UOP_NOP;
      w.cond   = COND_NEXT;
      w.target = UA_IGNORE;
      w.done   = 1'b0;
      unique case (addr)
         UA_DIGIT: begin
            w.uop  = UOP_DIGIT;
            w.done = 1'b1;
         end
         UA_POINT: begin
            w.uop  = UOP_POINT;
            w.done = 1'b1;
         end
         UA_CLEAR: begin
            w.uop  = UOP_CLEAR;
            w.done = 1'b1;
         end
         UA_IGNORE: begin
            w.done = 1'b1;
         end
         UA_EQUALS: begin
            w.cond   = COND_NO_PEND;
            w.target = UA_IGNORE;
         end
         UA_OPERATOR: begin
            w.cond   = COND_NO_CALC;
            w.target = UA_COMMIT;
         end
         UA_PEND_TYPE: begin
            w.cond   = COND_MUL_DIV;
            w.target = UA_LOAD_MUL;
         end
         UA_ADDSUB: begin
            w.uop    = UOP_ADDSUB;
            w.cond   = COND_ALWAYS;
            w.target = UA_COMMIT;
         end
         UA_LOAD_MUL: begin
            w.uop    = UOP_LOAD_MUL;
            w.cond   = COND_DIV_ZERO;
            w.target = UA_DIV_ZERO;
         end
         UA_MUL_LOOP: begin
            w.uop    = UOP_MUL_STEP;
            w.cond   = COND_MORE;
            w.target = UA_MUL_LOOP;
         end
         UA_LOAD_DIV: begin
            w.uop = UOP_LOAD_DIV;
         end
         UA_DIV_LOOP: begin
            w.uop    = UOP_DIV_STEP;
            w.cond   = COND_MORE;
            w.target = UA_DIV_LOOP;
         end
         UA_FINISH: begin
            w.uop = UOP_FINISH;
         end
         UA_COMMIT: begin
            w.uop  = UOP_COMMIT;
            w.done = 1'b1;
         end
         UA_DIV_ZERO: begin
            w.uop  = UOP_DIV_ZERO;
            w.done = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

>>> hdl/four_function_calculator_core.sv
// Four-function calculator core: microcoded sequencer over a shift-add/restoring-divide datapath.
// Digit, point, clear and ignored keys run a single microcode word each; operator and equals keys
// may first apply the pending add, subtract, multiply or divide.
// Multiply and divide run the shift-add multiply loop, one bit per cycle, followed by the restoring
// divide over the double-width product.
// One request is in the sequencer at a time. Reset is synchronous and clears all calculator state.
module four_function_calculator_core
   import ffc_pkg::*;
#(
   parameter int VALUE_WIDTH = 48,
   parameter int FRAC_DIGITS = 6
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   // Value width, digit entry width with headroom for ten times a value plus a digit,
   // product width, and loop counter width.
   localparam int VW = VALUE_WIDTH;
   localparam int EW = VW + 4;
   localparam int PW = 2 * VW;
   localparam int IW = $clog2(PW + 1);
   localparam int DW = SCALE_W + 4;

   localparam logic [VW-1:0]      MAX_POS  = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0]      MIN_MAG  = {1'b1, {(VW-1){1'b0}}};
   localparam logic [SCALE_W-1:0] SCALE    = pow_ten(3'(FRAC_DIGITS));
   localparam logic [2:0]         FRAC_MAX = 3'(FRAC_DIGITS);

   // Calculator state.
   logic [VW-1:0]       cur_ff, cur_in;
   logic [VW-1:0]       prev_ff, prev_in;
   logic [PEND_W-1:0]   pend_ff, pend_in;
   logic                newnum_ff, newnum_in;
   logic                point_ff, point_in;
   logic [2:0]          frac_ff, frac_in;

   // Arithmetic datapath. The product register also serves as the dividend/quotient
   // shift register during the divide loop.
   logic [PW-1:0]       prod_ff, prod_in;
   logic [VW-1:0]       mcand_ff, mcand_in;
   logic [VW-1:0]       dsor_ff, dsor_in;
   logic [VW-1:0]       rem_ff, rem_in;
   logic [IW-1:0]       iter_ff, iter_in;
   logic                neg_ff, neg_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   // Sequencer.
   logic                busy_ff, busy_in;
   logic [PC_W-1:0]     pc_ff, pc_in;
   req_payload_type     key_ff, key_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   ucode_word_type      uword;
   logic                accept;
   logic                step_en;
   logic                take_jump;
   logic                pend_ok;
   logic [SHOWN_W-1:0]  shown_next;

   // Digit entry terms.
   logic [VW-1:0]       v_base;
   logic                point_base;
   logic [2:0]          frac_base;
   logic [DW-1:0]       dig_int;
   logic [DW-1:0]       dig_frac;
   logic [EW-1:0]       int_sum;
   logic [EW-1:0]       frac_sum;

   // Add and subtract terms.
   logic [VW:0]         as_sum;
   logic                as_over;

   // Multiply and divide terms.
   logic [VW-1:0]       mag_prev;
   logic [VW-1:0]       mag_cur;
   logic [VW:0]         mul_sum;
   logic [VW:0]         div_part;
   logic [VW:0]         div_diff;
   logic                div_ge;
   logic [VW-1:0]       fin_limit;
   logic                fin_over;
   logic [VW-1:0]       fin_mag;

   assign uword   = ucode_rom(pc_ff);
   assign accept  = req_valid & ~busy_ff;
   // A step that delivers a result waits while the result register still holds a stalled one.
   assign step_en = busy_ff & ~(uword.done & rsp_valid_ff & rsp_stall);
   assign pend_ok = (pend_ff >= PEND_ADD) && (pend_ff <= PEND_DIV);

   always_comb begin
      unique case (uword.cond)
         COND_NEXT:     take_jump = 1'b0;
         COND_ALWAYS:   take_jump = 1'b1;
         COND_NO_PEND:  take_jump = ~pend_ok;
         COND_NO_CALC:  take_jump = newnum_ff | ~pend_ok;
         COND_MUL_DIV:  take_jump = (pend_ff == PEND_MUL) || (pend_ff == PEND_DIV);
         COND_DIV_ZERO: take_jump = (pend_ff == PEND_DIV) && (cur_ff == '0);
         COND_MORE:     take_jump = (iter_ff != IW'(1));
         default:       take_jump = 1'b0;
      endcase
   end

   // A digit starts from a cleared entry when a new number is due.
   assign v_base     = newnum_ff ? '0 : cur_ff;
   assign point_base = newnum_ff ? 1'b0 : point_ff;
   assign frac_base  = newnum_ff ? 3'd0 : frac_ff;
   assign dig_int    = DW'(key_ff.digit) * DW'(SCALE);
   assign dig_frac   = DW'(key_ff.digit) * DW'(pow_ten(3'(FRAC_MAX - 3'd1 - frac_base)));
   assign int_sum    = (EW'(v_base) << 3) + (EW'(v_base) << 1) + EW'(dig_int);
   assign frac_sum   = EW'(v_base) + EW'(dig_frac);

   // Saturating add or subtract of the left operand and the entered number.
   assign as_sum  = (pend_ff == PEND_SUB) ? ({prev_ff[VW-1], prev_ff} - {cur_ff[VW-1], cur_ff})
                                          : ({prev_ff[VW-1], prev_ff} + {cur_ff[VW-1], cur_ff});
   assign as_over = as_sum[VW] ^ as_sum[VW-1];

   assign mag_prev = prev_ff[VW-1] ? (~prev_ff + 1'b1) : prev_ff;
   assign mag_cur  = cur_ff[VW-1] ? (~cur_ff + 1'b1) : cur_ff;

   // One shift-add multiply step: the multiplier sits in the low half and shifts out.
   assign mul_sum = {1'b0, prod_ff[PW-1:VW]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);

   // One restoring divide step: the dividend shifts out of the top, quotient bits in at the bottom.
   assign div_part = {rem_ff, prod_ff[PW-1]};
   assign div_diff = div_part - {1'b0, dsor_ff};
   assign div_ge   = (div_part >= {1'b0, dsor_ff});

   // Saturation limit of the magnitude depends on the sign of the result.
   assign fin_limit = neg_ff ? MIN_MAG : MAX_POS;
   assign fin_over  = (|prod_ff[PW-1:VW]) || (prod_ff[VW-1:0] > fin_limit);
   assign fin_mag   = fin_over ? fin_limit : prod_ff[VW-1:0];

   always_comb begin
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      pend_in   = pend_ff;
      newnum_in = newnum_ff;
      point_in  = point_ff;
      frac_in   = frac_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      dsor_in   = dsor_ff;
      rem_in    = rem_ff;
      iter_in   = iter_ff;
      neg_in    = neg_ff;
      status_in = status_ff;
      busy_in   = busy_ff;
      pc_in     = pc_ff;
      key_in    = key_ff;

      if (accept) begin
         busy_in   = 1'b1;
         pc_in     = entry_pc(req_data.kind);
         key_in    = req_data;
         status_in = STATUS_OK;
      end else if (step_en) begin
         if (uword.done) begin
            busy_in = 1'b0;
         end else if (take_jump) begin
            pc_in = uword.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end

         unique case (uword.uop)
            UOP_NOP: begin
            end
            UOP_DIGIT: begin
               // A key above nine leaves everything as it is.
               if (key_ff.digit <= 4'd9) begin
                  cur_in    = v_base;
                  point_in  = point_base;
                  frac_in   = frac_base;
                  newnum_in = 1'b0;
                  if (!v_base[VW-1]) begin
                     if (!point_base) begin
                        if (int_sum <= EW'(MAX_POS)) begin
                           cur_in = int_sum[VW-1:0];
                        end
                     end else if (frac_base < FRAC_MAX) begin
                        if (frac_sum <= EW'(MAX_POS)) begin
                           cur_in  = frac_sum[VW-1:0];
                           frac_in = frac_base + 3'd1;
                        end
                     end
                  end
               end
            end
            UOP_POINT: begin
               if (newnum_ff) begin
                  cur_in    = '0;
                  frac_in   = 3'd0;
                  newnum_in = 1'b0;
               end
               point_in = 1'b1;
            end
            UOP_CLEAR, UOP_DIV_ZERO: begin
               cur_in    = '0;
               prev_in   = '0;
               pend_in   = PEND_NONE;
               newnum_in = 1'b1;
               point_in  = 1'b0;
               frac_in   = 3'd0;
               if (uword.uop == UOP_DIV_ZERO) begin
                  status_in = STATUS_DIV_ZERO;
               end
            end
            UOP_ADDSUB: begin
               if (as_over) begin
                  cur_in    = as_sum[VW] ? MIN_MAG : MAX_POS;
                  status_in = STATUS_SAT;
               end else begin
                  cur_in = as_sum[VW-1:0];
               end
            end
            UOP_LOAD_MUL: begin
               // Multiply forms |a|*|b| then divides by the scale; divide forms |a|*scale
               // then divides by |b|.
               mcand_in = mag_prev;
               neg_in   = prev_ff[VW-1] ^ cur_ff[VW-1];
               iter_in  = IW'(VW);
               if (pend_ff == PEND_MUL) begin
                  prod_in = {{VW{1'b0}}, mag_cur};
                  dsor_in = VW'(SCALE);
               end else begin
                  prod_in = {{VW{1'b0}}, VW'(SCALE)};
                  dsor_in = mag_cur;
               end
            end
            UOP_MUL_STEP: begin
               prod_in = {mul_sum, prod_ff[VW-1:1]};
               iter_in = iter_ff - 1'b1;
            end
            UOP_LOAD_DIV: begin
               rem_in  = '0;
               iter_in = IW'(PW);
            end
            UOP_DIV_STEP: begin
               rem_in  = div_ge ? div_diff[VW-1:0] : div_part[VW-1:0];
               prod_in = {prod_ff[PW-2:0], div_ge};
               iter_in = iter_ff - 1'b1;
            end
            UOP_FINISH: begin
               cur_in = neg_ff ? (~fin_mag + 1'b1) : fin_mag;
               if (fin_over) begin
                  status_in = STATUS_SAT;
               end
            end
            UOP_COMMIT: begin
               prev_in   = cur_ff;
               newnum_in = 1'b1;
               if (key_ff.kind == KIND_OPERATOR) begin
                  pend_in = PEND_W'({1'b0, key_ff.op_code}) + PEND_ADD;
               end else begin
                  pend_in = PEND_NONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The shown value is the calculator value sign extended or cut to the display width.
   generate
      if (VW >= SHOWN_W) begin : g_cut
         assign shown_next = cur_in[SHOWN_W-1:0];
      end else begin : g_extend
         assign shown_next = {{(SHOWN_W-VW){cur_in[VW-1]}}, cur_in};
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step_en && uword.done) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.shown_value = shown_next;
         rsp_data_in.status      = status_in;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         prev_ff      <= '0;
         pend_ff      <= PEND_NONE;
         newnum_ff    <= 1'b1;
         point_ff     <= 1'b0;
         frac_ff      <= 3'd0;
         status_ff    <= STATUS_OK;
         busy_ff      <= 1'b0;
         pc_ff        <= UA_IGNORE;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         pend_ff      <= pend_in;
         newnum_ff    <= newnum_in;
         point_ff     <= point_in;
         frac_ff      <= frac_in;
         status_ff    <= status_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      mcand_ff    <= mcand_in;
      dsor_ff     <= dsor_in;
      rem_ff      <= rem_in;
      iter_ff     <= iter_in;
      neg_ff      <= neg_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
